FILE: design/kohonen_palette_trainer_defines.svh
// ----------------------------------------------------------------------------
// Kohonen palette trainer assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KOHONEN_PALETTE_TRAINER_DEFINES_SVH
`define KOHONEN_PALETTE_TRAINER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define KPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define KPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/kpt_pkg.sv
// ----------------------------------------------------------------------------
// Kohonen palette trainer package
// Sizes, register indexes and a helper function for the colour-map trainer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpt_pkg;

  // Map size and radius table depth.
  localparam int NEURONS = 256;
  localparam int RTD     = 32;

  localparam int NIDX_W  = $clog2(NEURONS);
  localparam int RTD_W   = $clog2(RTD);
  localparam int RAD_W   = $clog2(RTD + 1);

  // Fixed field and state widths.
  localparam int COMP_W  = 12;
  localparam int FREQ_W  = 17;
  localparam int BIAS_W  = 32;
  localparam int RATE_W  = 11;
  localparam int RADB_W  = 12;
  localparam int TBL_W   = 19;
  localparam int CNT_W   = 24;
  localparam int ALPHA_W = 6;
  localparam int DIST_W  = 14;

  // Shared divider widths: dividend holds the table numerator, divisor r*r.
  localparam int DIVA_W  = 2 * RAD_W + 8;
  localparam int DIVB_W  = 2 * RAD_W;
  localparam int DIVC_W  = $clog2(DIVA_W + 1);

  // Reset values.
  localparam int COLOR_STEP  = 4096 / NEURONS;
  localparam int FREQ_RESET  = 65536 / NEURONS;
  localparam int RATE_RESET  = 1024;
  localparam int RADB_RESET  = (NEURONS / 8) * 64;
  localparam int RAD_DECAY   = 30;

  // Radius decay by reciprocal: (x * 4370) >> 17 equals x / 30 for any
  // 12-bit x.
  localparam int RAD_RECIP    = 4370;
  localparam int RAD_RECIP_SH = 17;

  // Scales of the two kinds of move.
  localparam int SH_WIN = 10;
  localparam int SH_NB  = 18;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_DIVISOR = 1'd1;

  // Input mode codes.
  localparam logic MODE_TRAIN = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef logic [2:0][COMP_W-1:0] color_t;

  // Current radius in neurons from the biased radius.
  function automatic logic [RAD_W-1:0] cur_radius(input logic [RADB_W-1:0] rb);
    logic [RADB_W-7:0] r;
    logic [RAD_W-1:0]  res;
    r = rb[RADB_W-1:6];
    if (r <= (RADB_W-6)'(1)) begin
      res = '0;
    end else if (r > (RADB_W-6)'(RTD)) begin
      res = RAD_W'(RTD);
    end else begin
      res = RAD_W'(r);
    end
    return res;
  endfunction

endpackage

FILE: design/kohonen_palette_trainer.sv
// ----------------------------------------------------------------------------
// Kohonen palette trainer
// Self-organising 256-entry colour map with biased winner contest.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on the out_ ports for one cycle with out_valid, and the
// receiver cannot stall it. A training pixel passes through the scan and
// winner bookkeeping, moves each neuron (the winner plus up to 2*(r-1)
// neighbours) through one multiplier, then does the count and report; at
// the end of each learning cycle the serial divider runs for the decay
// (the radius decay is a single reciprocal multiply) and for the table
// rebuild. Each neuron passes through the colour, frequency and bias
// memories, each with one read and one write port. After reset the block
// clears the memories and builds the radius table with busy high.
`timescale 1ns / 1ps
`include "kohonen_palette_trainer_defines.svh"

module kohonen_palette_trainer import kpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_neuron_index,
  output logic                  out_valid,
  output logic [7:0]            out_winner,
  output logic [7:0]            out_color_red,
  output logic [7:0]            out_color_green,
  output logic [7:0]            out_color_blue,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [20:0] {
    ST_CLEAR    = 21'h000001,
    ST_IDLE     = 21'h000002,
    ST_RD       = 21'h000004,
    ST_RDOUT    = 21'h000008,
    ST_SCAN     = 21'h000010,
    ST_SCAN_END = 21'h000020,
    ST_WIN_RD   = 21'h000040,
    ST_WIN_WR   = 21'h000080,
    ST_MV_RD    = 21'h000100,
    ST_MV_LOAD  = 21'h000200,
    ST_MV_MUL   = 21'h000400,
    ST_MV_ACC   = 21'h000800,
    ST_MV_WR    = 21'h001000,
    ST_NEXT     = 21'h002000,
    ST_CNT      = 21'h004000,
    ST_DIV      = 21'h008000,
    ST_RATE_UPD = 21'h010000,
    ST_RAD_UPD  = 21'h020000,
    ST_TB_START = 21'h040000,
    ST_TB_WR    = 21'h080000,
    ST_DONE     = 21'h100000
  } state_t;

  // Control state.
  state_t              state_r, state_nxt, div_ret_r, div_ret_nxt;
  logic                init_r, init_nxt;
  logic [NIDX_W:0]     cnt_i_r, cnt_i_nxt;
  logic                proc_v_r, proc_v_nxt;
  logic [CNT_W-1:0]    cycle_len_r, cycle_len_nxt;
  logic [ALPHA_W-1:0]  alpha_div_r, alpha_div_nxt;
  logic [CNT_W-1:0]    cycle_cnt_r, cycle_cnt_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [RADB_W-1:0]   radb_r, radb_nxt;
  logic [DIVC_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [RAD_W-1:0]    nb_m_r, nb_m_nxt;
  logic                nb_side_r, nb_side_nxt;
  logic [1:0]          comp_r, comp_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  logic                mode_r, mode_nxt;
  color_t              px_r, px_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [NIDX_W-1:0]   proc_i_r, proc_i_nxt;
  logic [DIST_W-1:0]   best_d_r, best_d_nxt;
  logic [NIDX_W-1:0]   best_pos_r, best_pos_nxt;
  logic signed [32:0]  best_bd_r, best_bd_nxt;
  logic [NIDX_W-1:0]   best_bpos_r, best_bpos_nxt;
  logic [NIDX_W-1:0]   mv_addr_r, mv_addr_nxt;
  logic [TBL_W:0]      mv_fac_r, mv_fac_nxt;
  logic                mv_nb_r, mv_nb_nxt;
  color_t              work_r, work_nxt;
  logic signed [32:0]  prod_r, prod_nxt;
  logic [DIVA_W-1:0]   div_a_r, div_a_nxt;
  logic [DIVB_W-1:0]   div_b_r, div_b_nxt;
  logic [DIVB_W-1:0]   div_rem_r, div_rem_nxt;
  logic [RAD_W-1:0]    tb_d_r, tb_d_nxt;
  logic [7:0]          out_winner_r, out_winner_nxt;
  logic [2:0][7:0]     out_color_r, out_color_nxt;

  // Memories and the radius table.
  logic [3*COMP_W-1:0] col_mem [NEURONS];
  logic [FREQ_W-1:0]   freq_mem [NEURONS];
  logic [BIAS_W-1:0]   bias_mem [NEURONS];
  logic [TBL_W-1:0]    tbl_r [RTD];

  logic [3*COMP_W-1:0] col_rd_r;
  logic [FREQ_W-1:0]   freq_rd_r;
  logic [BIAS_W-1:0]   bias_rd_r;

  logic                col_we, fb_we, tbl_we;
  logic [NIDX_W-1:0]   col_ra, col_wa, fb_ra, fb_wa;
  logic [3*COMP_W-1:0] col_wd;
  logic [FREQ_W-1:0]   freq_wd;
  logic [BIAS_W-1:0]   bias_wd;
  logic [RTD_W-1:0]    tbl_wa;
  logic [TBL_W-1:0]    tbl_wd;

  // Combinational helpers.
  color_t              rd_col;
  logic [DIST_W-1:0]   man_dist;
  logic signed [32:0]  bdist;
  logic [6:0]          bf;
  logic [RAD_W-1:0]    rad_cur;
  logic [NIDX_W:0]     nb_j;
  logic signed [12:0]  diff_s;
  logic signed [33:0]  p_adj, q_mv, v_mv;
  logic [DIVB_W:0]     div_trial;
  logic                div_bit;
  logic [DIVB_W-1:0]   tb_rr, tb_dd;
  logic [DIVA_W-1:0]   tb_num;
  logic [RATE_W+DIVA_W-1:0] tb_prod;
  logic [RADB_W+12:0]  rad_prod;
  logic [CNT_W-1:0]    cnt_inc, cycle_len_eff;
  logic [COMP_W-1:0]   round_c;

  assign rd_col  = col_rd_r;
  assign rad_cur = cur_radius(radb_r);

  // Distance and bookkeeping for the neuron coming out of the memories.
  always_comb begin
    man_dist = '0;
    for (int k = 0; k < 3; k++) begin
      if (rd_col[k] > px_r[k]) begin
        man_dist = man_dist + DIST_W'(rd_col[k] - px_r[k]);
      end else begin
        man_dist = man_dist + DIST_W'(px_r[k] - rd_col[k]);
      end
    end
    bdist = $signed({19'b0, man_dist}) - 33'($signed(bias_rd_r) >>> 12);
    bf    = freq_rd_r[FREQ_W-1:10];
  end

  // Move arithmetic: truncating division by the scale; the sequencer clamps.
  always_comb begin
    diff_s = $signed({1'b0, work_r[comp_r]}) - $signed({1'b0, px_r[comp_r]});
    if (prod_r < 0) begin
      p_adj = 34'(prod_r) + (mv_nb_r ? 34'sd262143 : 34'sd1023);
    end else begin
      p_adj = 34'(prod_r);
    end
    q_mv = mv_nb_r ? (p_adj >>> SH_NB) : (p_adj >>> SH_WIN);
    v_mv = $signed({22'b0, work_r[comp_r]}) - q_mv;
  end

  // Serial divider step and table terms.
  always_comb begin
    div_trial = {div_rem_r, div_a_r[DIVA_W-1]};
    div_bit   = (div_trial >= {1'b0, div_b_r});
    tb_rr     = DIVB_W'(cur_radius(radb_r)) * DIVB_W'(cur_radius(radb_r));
    tb_dd     = DIVB_W'(tb_d_r) * DIVB_W'(tb_d_r);
    tb_num    = DIVA_W'(tb_rr - tb_dd) << 8;
    tb_prod   = (RATE_W+DIVA_W)'(rate_r) * (RATE_W+DIVA_W)'(div_a_r);
    rad_prod  = (RADB_W+13)'(radb_r) * (RADB_W+13)'(RAD_RECIP);
    cnt_inc   = cycle_cnt_r + CNT_W'(1);
    cycle_len_eff = (cycle_len_r == '0) ? CNT_W'(1) : cycle_len_r;
    nb_j      = {1'b0, best_bpos_r} + (NIDX_W+1)'(nb_m_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    div_ret_nxt   = div_ret_r;
    init_nxt      = init_r;
    cnt_i_nxt     = cnt_i_r;
    proc_v_nxt    = proc_v_r;
    cycle_len_nxt = cycle_len_r;
    alpha_div_nxt = alpha_div_r;
    cycle_cnt_nxt = cycle_cnt_r;
    rate_nxt      = rate_r;
    radb_nxt      = radb_r;
    div_cnt_nxt   = div_cnt_r;
    nb_m_nxt      = nb_m_r;
    nb_side_nxt   = nb_side_r;
    comp_nxt      = comp_r;
    out_valid_nxt = 1'b0;
    mode_nxt      = mode_r;
    px_nxt        = px_r;
    idx_nxt       = idx_r;
    proc_i_nxt    = proc_i_r;
    best_d_nxt    = best_d_r;
    best_pos_nxt  = best_pos_r;
    best_bd_nxt   = best_bd_r;
    best_bpos_nxt = best_bpos_r;
    mv_addr_nxt   = mv_addr_r;
    mv_fac_nxt    = mv_fac_r;
    mv_nb_nxt     = mv_nb_r;
    work_nxt      = work_r;
    prod_nxt      = prod_r;
    div_a_nxt     = div_a_r;
    div_b_nxt     = div_b_r;
    div_rem_nxt   = div_rem_r;
    tb_d_nxt      = tb_d_r;
    out_winner_nxt = out_winner_r;
    out_color_nxt  = out_color_r;
    col_we  = 1'b0;
    fb_we   = 1'b0;
    tbl_we  = 1'b0;
    col_ra  = mv_addr_r;
    col_wa  = mv_addr_r;
    fb_ra   = '0;
    fb_wa   = proc_i_r;
    col_wd  = work_r;
    freq_wd = freq_rd_r - FREQ_W'(bf);
    bias_wd = bias_rd_r + {15'b0, bf, 10'b0};
    tbl_wa  = tb_d_r[RTD_W-1:0];
    tbl_wd  = tb_prod[TBL_W-1:0];
    round_c = '0;

    // Configuration writes are taken in any state.
    if (cfg_we) begin
      if (cfg_index == CFG_CYCLE_LENGTH) begin
        cycle_len_nxt = cfg_data;
      end else if (cfg_index == CFG_ALPHA_DIVISOR) begin
        alpha_div_nxt = cfg_data[ALPHA_W-1:0];
      end
    end

    // Scan pipeline: contest and frequency/bias update for one neuron.
    if ((state_r == ST_SCAN || state_r == ST_SCAN_END) && proc_v_r) begin
      fb_we = 1'b1;
      if (proc_i_r == '0 || man_dist < best_d_r) begin
        best_d_nxt   = man_dist;
        best_pos_nxt = proc_i_r;
      end
      if (proc_i_r == '0 || bdist < best_bd_r) begin
        best_bd_nxt   = bdist;
        best_bpos_nxt = proc_i_r;
      end
    end

    case (state_r)
      // Reset pass over the memories.
      ST_CLEAR: begin
        col_we  = 1'b1;
        fb_we   = 1'b1;
        col_wa  = cnt_i_r[NIDX_W-1:0];
        fb_wa   = cnt_i_r[NIDX_W-1:0];
        col_wd  = {3{COMP_W'(32'(cnt_i_r) * COLOR_STEP)}};
        freq_wd = FREQ_W'(FREQ_RESET);
        bias_wd = '0;
        cnt_i_nxt = cnt_i_r + (NIDX_W+1)'(1);
        if (cnt_i_r == (NIDX_W+1)'(NEURONS - 1)) begin
          tb_d_nxt  = '0;
          state_nxt = ST_TB_START;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          px_nxt    = {{in_blue, 4'b0}, {in_green, 4'b0}, {in_red, 4'b0}};
          idx_nxt   = in_neuron_index;
          cnt_i_nxt = '0;
          proc_v_nxt = 1'b0;
          state_nxt = (in_mode == MODE_READ) ? ST_RD : ST_SCAN;
        end
      end
      // Read transaction.
      ST_RD: begin
        col_ra    = idx_r[NIDX_W-1:0];
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        out_valid_nxt  = 1'b1;
        out_winner_nxt = '0;
        for (int k = 0; k < 3; k++) begin
          round_c = COMP_W'(rd_col[k] + COMP_W'(8)) >> 4;
          if (rd_col[k] >= COMP_W'(4088)) begin
            out_color_nxt[k] = 8'hFF;
          end else begin
            out_color_nxt[k] = round_c[7:0];
          end
          if ({1'b0, idx_r} >= 9'(NEURONS)) begin
            out_color_nxt[k] = '0;
          end
        end
        state_nxt = ST_IDLE;
      end
      // Issue one neuron per cycle to the scan pipeline.
      ST_SCAN: begin
        col_ra     = cnt_i_r[NIDX_W-1:0];
        fb_ra      = cnt_i_r[NIDX_W-1:0];
        proc_v_nxt = 1'b1;
        proc_i_nxt = cnt_i_r[NIDX_W-1:0];
        cnt_i_nxt  = cnt_i_r + (NIDX_W+1)'(1);
        if (cnt_i_r == (NIDX_W+1)'(NEURONS - 1)) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        proc_v_nxt = 1'b0;
        state_nxt  = ST_WIN_RD;
      end
      // Frequency gain and bias penalty for the unbiased winner.
      ST_WIN_RD: begin
        fb_ra     = best_pos_r;
        state_nxt = ST_WIN_WR;
      end
      ST_WIN_WR: begin
        fb_we       = 1'b1;
        fb_wa       = best_pos_r;
        freq_wd     = freq_rd_r + FREQ_W'(64);
        bias_wd     = bias_rd_r - 32'd65536;
        mv_addr_nxt = best_bpos_r;
        mv_fac_nxt  = (TBL_W+1)'(rate_r);
        mv_nb_nxt   = 1'b0;
        nb_m_nxt    = RAD_W'(1);
        nb_side_nxt = 1'b0;
        state_nxt   = ST_MV_RD;
      end
      // Move one neuron, one colour component at a time.
      ST_MV_RD: begin
        state_nxt = ST_MV_LOAD;
      end
      ST_MV_LOAD: begin
        work_nxt  = rd_col;
        comp_nxt  = 2'd0;
        state_nxt = ST_MV_MUL;
      end
      ST_MV_MUL: begin
        prod_nxt  = 33'($signed(mv_fac_r)) * 33'(diff_s);
        state_nxt = ST_MV_ACC;
      end
      ST_MV_ACC: begin
        if (v_mv < 0) begin
          work_nxt[comp_r] = '0;
        end else if (v_mv > 34'sd4095) begin
          work_nxt[comp_r] = COMP_W'(4095);
        end else begin
          work_nxt[comp_r] = v_mv[COMP_W-1:0];
        end
        comp_nxt  = comp_r + 2'd1;
        state_nxt = (comp_r == 2'd2) ? ST_MV_WR : ST_MV_MUL;
      end
      ST_MV_WR: begin
        col_we    = 1'b1;
        state_nxt = ST_NEXT;
      end
      // Walk the neighbours: above the winner, then below, for each offset.
      ST_NEXT: begin
        mv_nb_nxt  = 1'b1;
        mv_fac_nxt = {1'b0, tbl_r[nb_m_r[RTD_W-1:0]]};
        if (nb_m_r >= rad_cur) begin
          state_nxt = ST_CNT;
        end else if (!nb_side_r) begin
          nb_side_nxt = 1'b1;
          if (nb_j < (NIDX_W+1)'(NEURONS)) begin
            mv_addr_nxt = nb_j[NIDX_W-1:0];
            state_nxt   = ST_MV_RD;
          end
        end else begin
          nb_side_nxt = 1'b0;
          nb_m_nxt    = nb_m_r + RAD_W'(1);
          if ({1'b0, best_bpos_r} >= (NIDX_W+1)'(nb_m_r)) begin
            mv_addr_nxt = best_bpos_r - NIDX_W'(nb_m_r);
            state_nxt   = ST_MV_RD;
          end
        end
      end
      // Learning cycle count and decay.
      ST_CNT: begin
        if (cnt_inc >= cycle_len_eff) begin
          cycle_cnt_nxt = '0;
          if (alpha_div_r != '0) begin
            div_rem_nxt = '0;
            div_cnt_nxt = DIVC_W'(DIVA_W);
            div_a_nxt   = DIVA_W'(rate_r);
            div_b_nxt   = DIVB_W'(alpha_div_r);
            div_ret_nxt = ST_RATE_UPD;
            state_nxt   = ST_DIV;
          end else begin
            state_nxt   = ST_RAD_UPD;
          end
        end else begin
          cycle_cnt_nxt = cnt_inc;
          state_nxt     = ST_DONE;
        end
      end
      // Restoring divider, one quotient bit per cycle.
      ST_DIV: begin
        div_a_nxt   = {div_a_r[DIVA_W-2:0], div_bit};
        div_rem_nxt = div_bit ? DIVB_W'(div_trial - {1'b0, div_b_r})
                              : div_trial[DIVB_W-1:0];
        div_cnt_nxt = div_cnt_r - DIVC_W'(1);
        if (div_cnt_r == DIVC_W'(1)) begin
          state_nxt = div_ret_r;
        end
      end
      ST_RATE_UPD: begin
        rate_nxt  = rate_r - RATE_W'(div_a_r);
        state_nxt = ST_RAD_UPD;
      end
      // The radius loses a thirtieth through the reciprocal product.
      ST_RAD_UPD: begin
        radb_nxt  = radb_r - RADB_W'(rad_prod[RADB_W+12:RAD_RECIP_SH]);
        tb_d_nxt  = '0;
        state_nxt = ST_TB_START;
      end
      // Radius table rebuild, one entry per division.
      ST_TB_START: begin
        if (tb_d_r >= rad_cur) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_DONE;
        end else begin
          div_a_nxt   = tb_num;
          div_b_nxt   = tb_rr;
          div_rem_nxt = '0;
          div_cnt_nxt = DIVC_W'(DIVA_W);
          div_ret_nxt = ST_TB_WR;
          state_nxt   = ST_DIV;
        end
      end
      ST_TB_WR: begin
        tbl_we    = 1'b1;
        tb_d_nxt  = tb_d_r + RAD_W'(1);
        state_nxt = ST_TB_START;
      end
      ST_DONE: begin
        out_valid_nxt  = 1'b1;
        out_winner_nxt = 8'(best_bpos_r);
        out_color_nxt  = '0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      div_ret_r   <= ST_IDLE;
      init_r      <= 1'b1;
      cnt_i_r     <= '0;
      proc_v_r    <= 1'b0;
      cycle_len_r <= CNT_W'(1);
      alpha_div_r <= ALPHA_W'(30);
      cycle_cnt_r <= '0;
      rate_r      <= RATE_W'(RATE_RESET);
      radb_r      <= RADB_W'(RADB_RESET);
      div_cnt_r   <= '0;
      nb_m_r      <= '0;
      nb_side_r   <= 1'b0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_ret_r   <= div_ret_nxt;
      init_r      <= init_nxt;
      cnt_i_r     <= cnt_i_nxt;
      proc_v_r    <= proc_v_nxt;
      cycle_len_r <= cycle_len_nxt;
      alpha_div_r <= alpha_div_nxt;
      cycle_cnt_r <= cycle_cnt_nxt;
      rate_r      <= rate_nxt;
      radb_r      <= radb_nxt;
      div_cnt_r   <= div_cnt_nxt;
      nb_m_r      <= nb_m_nxt;
      nb_side_r   <= nb_side_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    px_r         <= px_nxt;
    idx_r        <= idx_nxt;
    proc_i_r     <= proc_i_nxt;
    best_d_r     <= best_d_nxt;
    best_pos_r   <= best_pos_nxt;
    best_bd_r    <= best_bd_nxt;
    best_bpos_r  <= best_bpos_nxt;
    mv_addr_r    <= mv_addr_nxt;
    mv_fac_r     <= mv_fac_nxt;
    mv_nb_r      <= mv_nb_nxt;
    work_r       <= work_nxt;
    prod_r       <= prod_nxt;
    div_a_r      <= div_a_nxt;
    div_b_r      <= div_b_nxt;
    div_rem_r    <= div_rem_nxt;
    tb_d_r       <= tb_d_nxt;
    out_winner_r <= out_winner_nxt;
    out_color_r  <= out_color_nxt;
  end

  // Colour memory.
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    col_rd_r <= col_mem[col_ra];
  end

  // Frequency and bias memories, sharing one address.
  always_ff @(posedge clk) begin
    if (fb_we) begin
      freq_mem[fb_wa] <= freq_wd;
      bias_mem[fb_wa] <= bias_wd;
    end
    freq_rd_r <= freq_mem[fb_ra];
    bias_rd_r <= bias_mem[fb_ra];
  end

  // Radius table.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[tbl_wa] <= tbl_wd;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_winner      = out_winner_r;
  assign out_color_red   = out_color_r[0];
  assign out_color_green = out_color_r[1];
  assign out_color_blue  = out_color_r[2];

  // Single strobe, busy on accept, result when idle, no colour when training.
  `KPT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe lasted two cycles")
  `KPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `KPT_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while still busy")
  `KPT_ASSERT_SAME(a_train_nocolor, out_valid && mode_r == MODE_TRAIN,
                   out_color_r == '0, "training result carries colour")

endmodule
